FILE: sv/met_pkg.sv
// shared types, constants and helpers for the escape-time pixel engine
`timescale 1ns / 1ps

package met_pkg;

    // fixed field widths
    localparam int COORD_W   = 10;
    localparam int DIM_W     = 11;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int ITER_W    = 16;

    // mapping divider: |pos * span| fits in 43 bits, divisor is dim - 1
    localparam int DVD_W = 43;
    localparam int DVS_W = DIM_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RE      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IM      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IM      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_RSQ  = 4'd7;

    // configuration reset values
    localparam logic signed [WORD_W-1:0] RST_MIN_RE = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_MAX_RE = 32'sd268435456;
    localparam logic signed [WORD_W-1:0] RST_MIN_IM = -32'sd402653184;
    localparam logic signed [WORD_W-1:0] RST_MAX_IM = 32'sd402653184;
    localparam logic [DIM_W-1:0]         RST_IMAGE_W = 11'd512;
    localparam logic [DIM_W-1:0]         RST_IMAGE_H = 11'd512;
    localparam int                       RST_MAX_ITER = 120;
    localparam logic [WORD_W-1:0]        RST_ESCAPE_RSQ = 32'd1073741824;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_MAP,
        S_ITER,
        S_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic mult;
        logic div_start;
        logic map;
        logic iter;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic iter_done;
        logic out_free;
    } t_status;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

FILE: sv/met_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module met_div
    import met_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_busy
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // control: busy flag and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_dvd;
    assign o_busy     = r_busy;

endmodule

FILE: sv/met_datapath.sv
// datapath: config registers, coordinate mapping, z iteration, result register
`timescale 1ns / 1ps

module met_datapath
    import met_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    input  logic [COORD_W-1:0]     i_column,
    input  logic [COORD_W-1:0]     i_row,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [COUNT_WIDTH-1:0] o_iteration_count,
    output logic                   o_escaped
);

    localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM > 2047) ? 11'd2047 : DIM_W'(MAX_DIM);

    // configuration registers
    logic signed [WORD_W-1:0] r_min_re, r_max_re, r_min_im, r_max_im;
    logic [DIM_W-1:0]         r_image_w, r_image_h;
    logic [ITER_W-1:0]        r_max_iter;
    logic [WORD_W-1:0]        r_rsq;

    // per-item registers
    logic [COORD_W-1:0]       r_col, r_row;
    logic signed [43:0]       r_prod_re, r_prod_im;
    logic                     r_neg_re, r_neg_im;
    logic signed [WORD_W-1:0] r_cre, r_cim, r_zr, r_zi;
    logic [ITER_W-1:0]        r_count, r_res_count;
    logic                     r_first, r_res_esc;

    // output register
    logic                     r_out_valid;
    logic [COUNT_WIDTH-1:0]   r_out_count;
    logic                     r_out_esc;

    logic [DIM_W-1:0]         w_dim_re, w_dim_im;
    logic signed [32:0]       w_span_re, w_span_im;
    logic signed [43:0]       w_abs_re, w_abs_im;
    logic [DVD_W-1:0]         w_q_re, w_q_im;
    logic                     w_busy_re, w_busy_im;
    logic signed [43:0]       w_off_re, w_off_im;
    logic signed [32:0]       w_sum_re, w_sum_im, w_adj_re, w_adj_im;
    logic signed [WORD_W-1:0] w_mid_re, w_mid_im;
    logic signed [63:0]       w_p_rr, w_p_ii, w_p_ri;
    logic signed [63:0]       w_s_rr, w_s_ii, w_s_ri, w_mag;
    logic signed [WORD_W-1:0] w_nr, w_ni;
    logic [ITER_W-1:0]        w_cnt_n;
    logic                     w_esc_hit, w_cont;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_re   <= RST_MIN_RE;
            r_max_re   <= RST_MAX_RE;
            r_min_im   <= RST_MIN_IM;
            r_max_im   <= RST_MAX_IM;
            r_image_w  <= RST_IMAGE_W;
            r_image_h  <= RST_IMAGE_H;
            r_max_iter <= ITER_W'(RST_MAX_ITER);
            r_rsq      <= RST_ESCAPE_RSQ;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_RE:     r_min_re   <= i_cfg_data;
                CFG_MAX_RE:     r_max_re   <= i_cfg_data;
                CFG_MIN_IM:     r_min_im   <= i_cfg_data;
                CFG_MAX_IM:     r_max_im   <= i_cfg_data;
                CFG_IMAGE_W:    r_image_w  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_H:    r_image_h  <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_ITER:   r_max_iter <= i_cfg_data[ITER_W-1:0];
                CFG_ESCAPE_RSQ: r_rsq      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimensions: zero acts as one, capped at the maximum
    always_comb begin
        w_dim_re = (r_image_w > DIM_CAP) ? DIM_CAP : r_image_w;
        if (w_dim_re == '0) begin
            w_dim_re = DIM_W'(1);
        end
        w_dim_im = (r_image_h > DIM_CAP) ? DIM_CAP : r_image_h;
        if (w_dim_im == '0) begin
            w_dim_im = DIM_W'(1);
        end
    end

    // spans, magnitudes and midpoints for the linear map
    always_comb begin
        w_span_re = 33'(r_max_re) - 33'(r_min_re);
        w_span_im = 33'(r_max_im) - 33'(r_min_im);
        w_abs_re  = r_prod_re[43] ? -r_prod_re : r_prod_re;
        w_abs_im  = r_prod_im[43] ? -r_prod_im : r_prod_im;
        w_sum_re  = 33'(r_min_re) + 33'(r_max_re);
        w_sum_im  = 33'(r_min_im) + 33'(r_max_im);
        // halve toward zero
        w_adj_re  = w_sum_re + $signed({32'b0, w_sum_re[32]});
        w_adj_im  = w_sum_im + $signed({32'b0, w_sum_im[32]});
        w_mid_re  = 32'(w_adj_re >>> 1);
        w_mid_im  = 32'(w_adj_im >>> 1);
        w_off_re  = r_neg_re ? -$signed({1'b0, w_q_re}) : $signed({1'b0, w_q_re});
        w_off_im  = r_neg_im ? -$signed({1'b0, w_q_im}) : $signed({1'b0, w_q_im});
    end

    // one divider per axis, both started together
    met_div u_div_re (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs_re[DVD_W-1:0]),
        .i_divisor  (w_dim_re - DIM_W'(1)),
        .o_quotient (w_q_re),
        .o_busy     (w_busy_re)
    );

    met_div u_div_im (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs_im[DVD_W-1:0]),
        .i_divisor  (w_dim_im - DIM_W'(1)),
        .o_quotient (w_q_im),
        .o_busy     (w_busy_im)
    );

    // squares and cross product of the current z
    always_comb begin
        w_p_rr = 64'(r_zr) * 64'(r_zr);
        w_p_ii = 64'(r_zi) * 64'(r_zi);
        w_p_ri = 64'(r_zr) * 64'(r_zi);
        w_s_rr = w_p_rr >>> FRAC_BITS;
        w_s_ii = w_p_ii >>> FRAC_BITS;
        w_s_ri = w_p_ri >>> (FRAC_BITS - 1);
        w_mag  = w_s_rr + w_s_ii;
        w_nr   = sat32(w_s_rr - w_s_ii + 64'(r_cre));
        w_ni   = sat32(w_s_ri + 64'(r_cim));
    end

    // escape test on the current z, then counter step
    always_comb begin
        w_esc_hit = !r_first && (w_mag > $signed({32'b0, r_rsq}));
        w_cnt_n   = r_first ? r_count : r_count + ITER_W'(1);
        w_cont    = (w_cnt_n < r_max_iter);
    end

    // request capture, mapping and iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (i_cmd.mult) begin
            r_prod_re <= 44'($signed({1'b0, r_col})) * 44'(w_span_re);
            r_prod_im <= 44'($signed({1'b0, r_row})) * 44'(w_span_im);
        end
        if (i_cmd.div_start) begin
            r_neg_re <= r_prod_re[43];
            r_neg_im <= r_prod_im[43];
        end
        if (i_cmd.map) begin
            r_cre   <= (w_dim_re == DIM_W'(1)) ? w_mid_re
                                               : sat32(64'(r_min_re) + 64'(w_off_re));
            r_cim   <= (w_dim_im == DIM_W'(1)) ? w_mid_im
                                               : sat32(64'(r_max_im) - 64'(w_off_im));
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= ITER_W'(1);
            r_first <= 1'b1;
        end
        if (i_cmd.iter) begin
            if (w_esc_hit) begin
                r_res_count <= r_count;
                r_res_esc   <= 1'b1;
            end else begin
                r_res_count <= w_cnt_n;
                r_res_esc   <= 1'b0;
                r_count     <= w_cnt_n;
                r_first     <= 1'b0;
                if (w_cont) begin
                    r_zr <= w_nr;
                    r_zi <= w_ni;
                end
            end
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload, count cut or widened to the port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_count <= COUNT_WIDTH'(r_res_count);
            r_out_esc   <= r_res_esc;
        end
    end

    // status back to the controller
    always_comb begin
        o_status.div_done  = !w_busy_re && !w_busy_im;
        o_status.iter_done = w_esc_hit || !w_cont;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_escaped         = r_out_esc;

endmodule

FILE: sv/met_ctrl.sv
// controller state machine sequencing map, divide, iterate and hand-off
`timescale 1ns / 1ps

module met_ctrl
    import met_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (i_status.div_done) n_state = S_MAP;
            S_MAP:    n_state = S_ITER;
            S_ITER:   if (i_status.iter_done) n_state = S_HOLD;
            S_HOLD:   if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_MUL:    o_cmd.mult      = 1'b1;
            S_DSTART: o_cmd.div_start = 1'b1;
            S_DIV:    ;
            S_MAP:    o_cmd.map       = 1'b1;
            S_ITER:   o_cmd.iter      = 1'b1;
            S_HOLD:   o_cmd.load_out  = i_status.out_free;
            default:  ;
        endcase
    end

endmodule

FILE: sv/mandelbrot_escape_time_top.sv
// escape-time engine: one request in, one iteration count out
// steps per request: capture, span multiply, divider start, the bit-serial divider,
// the coordinate map, the iteration loop, then loading the output register
// a new request is taken only once the last result is loaded; a finished result waiting behind a full
// output register stalls the input
// i_rst_n is synchronous active low; it restores the default plane, 512x512 image,
// 120 iterations and radius 2, and empties the output register
`timescale 1ns / 1ps

module mandelbrot_escape_time_top
    import met_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [COORD_W-1:0]     i_column,
    input  logic [COORD_W-1:0]     i_row,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_WIDTH-1:0] o_iteration_count,
    output logic                   o_escaped,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    met_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and registers
    met_datapath #(
        .MAX_DIM     (MAX_DIM),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_iteration_count (o_iteration_count),
        .o_escaped         (o_escaped)
    );

endmodule

FILE: test/mandelbrot_escape_time_top_tb.sv
// self-checking testbench for the mandelbrot escape-time pixel engine
`timescale 1ns / 1ps

module mandelbrot_escape_time_top_tb;
    import met_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int FRAC_BITS    = 28;
    localparam int COUNT_WIDTH  = 16;
    localparam int RANDOM_ITEMS = 850;
    localparam int LONG_HOLD    = 2000;
    localparam int TAIL_CYCLES  = 500;

    // index outside the register map, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

    // 4.0 in unsigned Q4.28
    localparam logic [WORD_W-1:0] RADIUS_SQ_TWO = 32'h4000_0000;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] iterations;
        logic                   escaped;
    } t_escape_result;

    typedef enum logic {
        STEP_WRITE,
        STEP_PIXEL
    } t_step_kind;

    typedef struct packed {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [WORD_W-1:0]      data;
        logic [COORD_W-1:0]     column;
        logic [COORD_W-1:0]     row;
        logic                   known;
        logic [COUNT_WIDTH-1:0] known_count;
        logic                   known_escaped;
    } t_directed_step;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [COORD_W-1:0]     i_column = '0;
    logic [COORD_W-1:0]     i_row = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [COUNT_WIDTH-1:0] o_iteration_count;
    logic                   o_escaped;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data = '0;

    // copy of the plane and loop settings as the block should hold them
    logic signed [WORD_W-1:0] plane_min_re = RST_MIN_RE;
    logic signed [WORD_W-1:0] plane_max_re = RST_MAX_RE;
    logic signed [WORD_W-1:0] plane_min_im = RST_MIN_IM;
    logic signed [WORD_W-1:0] plane_max_im = RST_MAX_IM;
    logic [DIM_W-1:0]         image_cols = RST_IMAGE_W;
    logic [DIM_W-1:0]         image_rows = RST_IMAGE_H;
    logic [15:0]              iteration_limit = 16'(RST_MAX_ITER);
    logic [WORD_W-1:0]        radius_sq = RST_ESCAPE_RSQ;

    t_escape_result predicted_escapes[$];
    int             fault_count = 0;
    int             burst_left = 0;

    // receiver stall control
    int       hold_requests = 0;
    int       holds_served = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    logic [1:0] sparse_phase = '0;

    mandelbrot_escape_time_top #(
        .MAX_DIM     (MAX_DIM),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_column          (i_column),
        .i_row             (i_row),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_iteration_count (o_iteration_count),
        .o_escaped         (o_escaped),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // clamp to the signed 32-bit coordinate range
    function automatic longint clamp_q428(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // zero counts as one pixel, oversize counts as the maximum
    function automatic longint clamp_dim(input logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return longint'(d);
    endfunction

    // pixel index to plane coordinate, division truncating toward zero
    function automatic longint axis_point(input longint pos, input longint lo,
                                          input longint hi, input longint dim,
                                          input bit downward);
        longint off;
        if (dim == 1) begin
            return clamp_q428((lo + hi) / 2);
        end
        off = (pos * (hi - lo)) / (dim - 1);
        return clamp_q428(downward ? hi - off : lo + off);
    endfunction

    // escape-time count for one pixel under the current settings
    function automatic t_escape_result escape_time(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
        longint c_re, c_im, zr, zi, nr, ni, limit, rsq, count;
        t_escape_result res;
        c_re  = axis_point(longint'(col), plane_min_re, plane_max_re,
                           clamp_dim(image_cols), 1'b0);
        c_im  = axis_point(longint'(row), plane_min_im, plane_max_im,
                           clamp_dim(image_rows), 1'b1);
        limit = longint'(iteration_limit);
        rsq   = longint'(radius_sq);
        zr    = 0;
        zi    = 0;
        count = 1;
        res.escaped = 1'b0;
        while (count < limit) begin
            nr = clamp_q428(((zr * zr) >>> FRAC_BITS) - ((zi * zi) >>> FRAC_BITS) + c_re);
            ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + c_im);
            zr = nr;
            zi = ni;
            if (((zr * zr) >>> FRAC_BITS) + ((zi * zi) >>> FRAC_BITS) > rsq) begin
                res.escaped = 1'b1;
                break;
            end
            count++;
        end
        res.iterations = COUNT_WIDTH'(count);
        return res;
    endfunction

    // directed table rows
    function automatic t_directed_step reg_step(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [WORD_W-1:0] data);
        return '{STEP_WRITE, idx, data, '0, '0, 1'b0, '0, 1'b0};
    endfunction

    function automatic t_directed_step pixel_step(input int col, input int row);
        return '{STEP_PIXEL, CFG_SPARE, '0, COORD_W'(col), COORD_W'(row), 1'b0, '0, 1'b0};
    endfunction

    function automatic t_directed_step known_step(input int col, input int row,
                                                  input int count, input bit esc);
        return '{STEP_PIXEL, CFG_SPARE, '0, COORD_W'(col), COORD_W'(row), 1'b1,
                 COUNT_WIDTH'(count), esc};
    endfunction

    // random dimension, mostly in range, sometimes zero or oversize
    function automatic logic [WORD_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return 32'd0;
        end
        if (pick == 1) begin
            return 32'd1;
        end
        if (pick == 2) begin
            return 32'($urandom_range(MAX_DIM + 1, 2047));
        end
        if (pick == 3) begin
            return 32'(MAX_DIM);
        end
        return 32'($urandom_range(2, MAX_DIM));
    endfunction

    // sometimes set the bits above a narrow register field
    function automatic logic [WORD_W-1:0] junk_above(input logic [WORD_W-1:0] v,
                                                     input int bits);
        if ($urandom_range(0, 3) == 0) begin
            return ($urandom() << bits) | v;
        end
        return v;
    endfunction

    // offer one pixel request; bursts of back-to-back requests with gaps between
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input bit use_known, input t_escape_result known);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_column   <= col;
        i_row      <= row;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted_escapes.push_back(use_known ? known : escape_time(col, row));
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    // stop offering and wait until every pixel result is back
    task automatic drain_results();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
        while (predicted_escapes.size() != 0) @(posedge i_clk);
    endtask

    // one register write, mirrored into the local settings when taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_RE:     plane_min_re = data;
            CFG_MAX_RE:     plane_max_re = data;
            CFG_MIN_IM:     plane_min_im = data;
            CFG_MAX_IM:     plane_max_im = data;
            CFG_IMAGE_W:    image_cols = data[DIM_W-1:0];
            CFG_IMAGE_H:    image_rows = data[DIM_W-1:0];
            CFG_MAX_ITER:   iteration_limit = data[15:0];
            CFG_ESCAPE_RSQ: radius_sq = data;
            default: ;
        endcase
    endtask

    // result receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= LONG_HOLD;
            i_out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 2));
                mode_left <= $urandom_range(50, 600);
            end else begin
                mode_left <= mode_left - 1;
            end
            sparse_phase <= sparse_phase + 2'd1;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                default:   i_out_ready <= (sparse_phase == 2'd0);
            endcase
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_escape_result want;
        t_escape_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_iteration_count, o_escaped};
            if (predicted_escapes.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result: count %0d escaped %0d",
                             got.iterations, got.escaped);
                end
            end else begin
                want = predicted_escapes.pop_front();
                if (want.iterations != got.iterations || want.escaped != got.escaped) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("mismatch: expected count %0d esc %0d, got count %0d esc %0d",
                                 want.iterations, want.escaped, got.iterations, got.escaped);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("mandelbrot_escape_time_top_tb: errors");
        $finish;
    end

    initial begin
        t_directed_step    steps [35];
        logic [WORD_W-1:0] reg_vals [8];
        int                sent;
        int                phase;
        int                phase_len;
        int                shape;
        int                re_lo, re_hi, im_lo, im_hi, swap_val;
        int                col_top, row_top;
        logic [COORD_W-1:0] col, row;

        steps = '{
            // default plane: corner escapes at once, far corner extrapolated
            known_step(0, 0, 1, 1'b1),
            known_step(1023, 1023, 1, 1'b1),
            pixel_step(256, 256),
            pixel_step(511, 255),
            // limits of one and zero run no iteration
            reg_step(CFG_MAX_ITER, 32'd1),
            known_step(300, 200, 1, 1'b0),
            reg_step(CFG_MAX_ITER, 32'd0),
            known_step(0, 0, 1, 1'b0),
            // zero dimensions map to the midpoint, origin never escapes
            reg_step(CFG_MAX_ITER, 32'd65535),
            reg_step(CFG_IMAGE_W, 32'd0),
            reg_step(CFG_IMAGE_H, 32'd0),
            reg_step(CFG_MIN_RE, 32'hF000_0000),
            reg_step(CFG_MAX_RE, 32'h1000_0000),
            reg_step(CFG_MIN_IM, 32'hF000_0000),
            reg_step(CFG_MAX_IM, 32'h1000_0000),
            known_step(0, 0, 65535, 1'b0),
            known_step(1023, 1023, 65535, 1'b0),
            // zero radius with c = 1 escapes on the first step
            reg_step(CFG_ESCAPE_RSQ, 32'd0),
            reg_step(CFG_MIN_RE, 32'h1000_0000),
            known_step(5, 5, 1, 1'b1),
            // full-range plane, oversize width, two rows, saturating coordinates
            reg_step(CFG_IMAGE_W, 32'h0000_07FF),
            reg_step(CFG_IMAGE_H, 32'd2),
            reg_step(CFG_MIN_RE, 32'h8000_0000),
            reg_step(CFG_MAX_RE, 32'h7FFF_FFFF),
            reg_step(CFG_MIN_IM, 32'h8000_0000),
            reg_step(CFG_MAX_IM, 32'h7FFF_FFFF),
            reg_step(CFG_MAX_ITER, 32'd200),
            reg_step(CFG_ESCAPE_RSQ, 32'hFFFF_FFFF),
            pixel_step(0, 0),
            pixel_step(1023, 1),
            pixel_step(1023, 1023),
            pixel_step(512, 0),
            reg_step(CFG_SPARE, 32'hFFFF_FFFF),
            pixel_step(700, 1),
            pixel_step(1, 0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (steps[k]) begin
            if (steps[k].kind == STEP_WRITE) begin
                drain_results();
                write_reg(steps[k].index, steps[k].data);
            end else begin
                send_pixel(steps[k].column, steps[k].row, steps[k].known,
                           '{steps[k].known_count, steps[k].known_escaped});
            end
        end

        // random phases, each with fresh settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            re_lo = int'($urandom_range(0, 32'h3000_0000)) - 32'sh2800_0000;
            re_hi = re_lo + int'($urandom_range(32'h0010_0000, 32'h3000_0000));
            im_lo = -int'($urandom_range(0, 32'h1800_0000));
            im_hi = im_lo + int'($urandom_range(32'h0010_0000, 32'h3000_0000));
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                re_lo = $urandom();
                re_hi = $urandom();
                im_lo = $urandom();
                im_hi = $urandom();
            end else if (shape == 1) begin
                swap_val = re_lo;
                re_lo    = re_hi;
                re_hi    = swap_val;
                swap_val = im_lo;
                im_lo    = im_hi;
                im_hi    = swap_val;
            end
            reg_vals[CFG_MIN_RE]  = re_lo;
            reg_vals[CFG_MAX_RE]  = re_hi;
            reg_vals[CFG_MIN_IM]  = im_lo;
            reg_vals[CFG_MAX_IM]  = im_hi;
            reg_vals[CFG_IMAGE_W] = junk_above(pick_dim(), DIM_W);
            reg_vals[CFG_IMAGE_H] = junk_above(pick_dim(), DIM_W);
            shape = $urandom_range(0, 19);
            if (shape == 0) begin
                reg_vals[CFG_MAX_ITER] = 32'd0;
            end else if (shape == 1) begin
                reg_vals[CFG_MAX_ITER] = 32'd1;
            end else if (shape == 2) begin
                reg_vals[CFG_MAX_ITER] = 32'($urandom_range(161, 400));
            end else begin
                reg_vals[CFG_MAX_ITER] = 32'($urandom_range(2, 160));
            end
            reg_vals[CFG_MAX_ITER] = junk_above(reg_vals[CFG_MAX_ITER], 16);
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
                reg_vals[CFG_ESCAPE_RSQ] = RADIUS_SQ_TWO;
            end else if (shape < 9) begin
                reg_vals[CFG_ESCAPE_RSQ] = $urandom_range(0, 32'h4FFF_FFFF);
            end else begin
                reg_vals[CFG_ESCAPE_RSQ] = $urandom();
            end

            drain_results();
            for (int r = CFG_MIN_RE; r <= CFG_ESCAPE_RSQ; r++) begin
                write_reg(CFG_IDX_W'(r), reg_vals[r]);
            end

            col_top   = int'(clamp_dim(image_cols)) - 1;
            row_top   = int'(clamp_dim(image_rows)) - 1;
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_ITEMS - sent) begin
                phase_len = RANDOM_ITEMS - sent;
            end
            for (int n = 0; n < phase_len; n++) begin
                // long receiver hold-off so the engine backs up into its input
                if ((phase == 0 || phase == 3) && n == 10) begin
                    hold_requests <= hold_requests + 1;
                end
                col = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom())
                                                  : COORD_W'($urandom_range(0, col_top));
                row = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom())
                                                  : COORD_W'($urandom_range(0, row_top));
                send_pixel(col, row, 1'b0, '0);
            end
            sent += phase_len;
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && predicted_escapes.size() == 0) begin
            $display("mandelbrot_escape_time_top_tb: clean");
        end else begin
            $display("mandelbrot_escape_time_top_tb: errors");
        end
        $finish;
    end

endmodule
